### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the partition allocator.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PFA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PFA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PFA_ASSERT(name, prop, msg)
`define PFA_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

### hw/rtl/pfa_pkg.sv
// Types, codes and sizes of the partition fit allocator.
// Depends on nothing; used by partition_fit_allocator.
package pfa_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned SIZE_BITS   = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned OWNER_W     = 16;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned PADDR_W     = 3;

  localparam logic [OWNER_W-1:0] OWNER_MAX = '1;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_ALLOC = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_WORST = 2'd2,
    POL_BEST  = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  localparam logic REG_FIT_POLICY = 1'b0;

  typedef struct packed {
    func_e       func;
    logic [15:0] size;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot_index;
    logic [OWNER_W-1:0]  owner_id;
    logic                did_split;
  } rsp_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] size;
    logic [OWNER_W-1:0]   owner;
  } entry_t;

endpackage

### hw/rtl/partition_fit_allocator.sv
// Sequence: an append answers in the cycle after start; a request scans in S_SCAN (first
// and next fit stop at a fit), S_DECIDE, on a split S_SHIFT as needed and S_INS, and S_FIN.
// Throughput: one item at a time; the next start is taken in the cycle the result shows.
// The table memory reads one entry per cycle, which sets the scan and shift length.
// Reset clears the entry count, next-fit cursor, request counter and policy register;
// the table memory is not cleared. The result strobe cannot be stalled.
`include "assert_macros.svh"
module partition_fit_allocator import pfa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  req_t               req_i,
  output logic               rsp_valid_o,
  output rsp_t               rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_INS    = 6'b010000,
    S_FIN    = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  policy_e              policy_q, policy_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     cursor_q, cursor_d;
  logic [OWNER_W-1:0]   req_cnt_q, req_cnt_d;
  logic [SIZE_BITS-1:0] want_q, want_d;
  logic [OWNER_W-1:0]   id_q, id_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]     iter_q, iter_d;
  logic                 have_q, have_d;
  logic [IDX_W-1:0]     pick_q, pick_d;
  logic [SIZE_BITS-1:0] pick_size_q, pick_size_d;
  logic                 split_q, split_d;
  logic                 rsp_valid_q, rsp_valid_d;
  rsp_t                 rsp_q, rsp_d;

  entry_t               mem_q [MAX_ENTRIES];
  entry_t               rdata_q;
  logic [IDX_W-1:0]     raddr;
  logic                 mem_we;
  logic [IDX_W-1:0]     waddr;
  entry_t               wdata;

  logic                 accept;
  logic                 cfg_we;
  logic                 cand;
  logic                 take;
  logic                 last;
  logic                 stop;
  logic [IDX_W-1:0]     pos_nxt;
  logic [IDX_W-1:0]     start_pos;
  logic [OWNER_W-1:0]   id_nxt;
  logic                 need_split;

  assign accept = start && !busy;
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FIT_POLICY) ? {30'd0, policy_q} : 32'd0;
  assign busy   = (state_q != S_IDLE);

  assign cand = (rdata_q.owner == '0) && (rdata_q.size >= want_q);
  assign take = cand && (!have_q ||
                         (policy_q == POL_WORST && rdata_q.size > pick_size_q) ||
                         (policy_q == POL_BEST  && rdata_q.size < pick_size_q));
  assign last = (iter_q + CNT_W'(1)) == count_q;
  assign stop = last || (cand && (policy_q == POL_FIRST || policy_q == POL_NEXT));
  assign pos_nxt = (({1'b0, pos_q} + CNT_W'(1)) >= count_q) ? '0 : pos_q + IDX_W'(1);
  assign start_pos = (policy_q == POL_NEXT && {1'b0, cursor_q} < count_q) ? cursor_q : '0;
  assign id_nxt = (req_cnt_q == OWNER_MAX) ? req_cnt_q : req_cnt_q + OWNER_W'(1);
  assign need_split = pick_size_q > want_q;

  always_comb begin
    state_d     = state_q;
    policy_d    = policy_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    req_cnt_d   = req_cnt_q;
    want_d      = want_q;
    id_d        = id_q;
    pos_d       = pos_q;
    iter_d      = iter_q;
    have_d      = have_q;
    pick_d      = pick_q;
    pick_size_d = pick_size_q;
    split_d     = split_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    raddr       = '0;
    mem_we      = 1'b0;
    waddr       = '0;
    wdata       = '0;

    if (cfg_we && paddr[2] == REG_FIT_POLICY) begin
      policy_d = policy_e'(pwdata[1:0]);
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rsp_d = '{status: ST_DONE, slot_index: '0, owner_id: '0, did_split: 1'b0};
          if (req_i.func == FUNC_LOAD) begin
            rsp_valid_d = 1'b1;
            if (count_q >= CNT_W'(MAX_ENTRIES)) begin
              rsp_d.status = ST_FULL;
            end else begin
              mem_we           = 1'b1;
              waddr            = count_q[IDX_W-1:0];
              wdata            = '{size: SIZE_BITS'(req_i.size), owner: '0};
              rsp_d.slot_index = SLOT_W'(count_q[IDX_W-1:0]);
              count_d          = count_q + CNT_W'(1);
            end
          end else begin
            req_cnt_d = id_nxt;
            id_d      = id_nxt;
            want_d    = SIZE_BITS'(req_i.size);
            if (count_q == '0) begin
              rsp_valid_d  = 1'b1;
              rsp_d.status = ST_NO_FIT;
            end else begin
              raddr   = start_pos;
              pos_d   = start_pos;
              iter_d  = '0;
              have_d  = 1'b0;
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (take) begin
          have_d      = 1'b1;
          pick_d      = pos_q;
          pick_size_d = rdata_q.size;
        end
        if (stop) begin
          state_d = S_DECIDE;
        end else begin
          raddr  = pos_nxt;
          pos_d  = pos_nxt;
          iter_d = iter_q + CNT_W'(1);
        end
      end
      S_DECIDE: begin
        split_d = need_split;
        rsp_d   = '{status: ST_DONE, slot_index: '0, owner_id: '0, did_split: 1'b0};
        if (!have_q) begin
          rsp_valid_d  = 1'b1;
          rsp_d.status = ST_NO_FIT;
          state_d      = S_IDLE;
        end else if (need_split && count_q >= CNT_W'(MAX_ENTRIES)) begin
          rsp_valid_d  = 1'b1;
          rsp_d.status = ST_FULL;
          state_d      = S_IDLE;
        end else if (!need_split) begin
          state_d = S_FIN;
        end else if (({1'b0, pick_q} + CNT_W'(1)) < count_q) begin
          raddr   = IDX_W'(count_q - CNT_W'(1));
          pos_d   = IDX_W'(count_q - CNT_W'(1));
          state_d = S_SHIFT;
        end else begin
          state_d = S_INS;
        end
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        waddr  = pos_q + IDX_W'(1);
        wdata  = rdata_q;
        if (pos_q == pick_q + IDX_W'(1)) begin
          state_d = S_INS;
        end else begin
          raddr = pos_q - IDX_W'(1);
          pos_d = pos_q - IDX_W'(1);
        end
      end
      S_INS: begin
        mem_we  = 1'b1;
        waddr   = pick_q + IDX_W'(1);
        wdata   = '{size: pick_size_q - want_q, owner: '0};
        count_d = count_q + CNT_W'(1);
        state_d = S_FIN;
      end
      S_FIN: begin
        mem_we = 1'b1;
        waddr  = pick_q;
        wdata  = '{size: want_q, owner: id_q};
        if (policy_q == POL_NEXT) begin
          cursor_d = pick_q;
        end
        rsp_valid_d = 1'b1;
        rsp_d = '{status: ST_DONE, slot_index: SLOT_W'(pick_q), owner_id: id_q,
                  did_split: split_q};
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      policy_q    <= POL_FIRST;
      count_q     <= '0;
      cursor_q    <= '0;
      req_cnt_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      policy_q    <= policy_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      req_cnt_q   <= req_cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    want_q      <= want_d;
    id_q        <= id_d;
    pos_q       <= pos_d;
    iter_q      <= iter_d;
    have_q      <= have_d;
    pick_q      <= pick_d;
    pick_size_q <= pick_size_d;
    split_q     <= split_d;
    rsp_q       <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `PFA_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_ENTRIES), "entry count beyond table depth")
  `PFA_ASSERT(a_no_write_in_scan, state_q == S_SCAN |-> !mem_we, "table written during a scan")
  `PFA_ASSERT(a_split_is_done, rsp_valid_o && rsp_o.did_split |-> rsp_o.status == ST_DONE,
              "split reported on a failed request")
  `PFA_ASSERT(a_alloc_goes_busy,
              accept && req_i.func == FUNC_ALLOC && count_q != '0 |=> busy,
              "request with a nonempty table did not start a scan")
  `PFA_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule
